// File: rtl/core/ptd_pkg.sv
// ----------------------------------------------------------------------------
// ptd_pkg: shared types and constants of the periodic task dispatcher.
// Holds the input and result word layouts, function and status codes.
// ----------------------------------------------------------------------------
package ptd_pkg;

	localparam logic [1:0] FUNC_TICK   = 2'd0;
	localparam logic [1:0] FUNC_CREATE = 2'd1;
	localparam logic [1:0] FUNC_QUERY  = 2'd2;
	localparam logic [1:0] FUNC_UNUSED = 2'd3;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_FULL     = 2'd1;
	localparam logic [1:0] ST_BAD      = 2'd2;
	localparam logic [1:0] ST_NOTFOUND = 2'd3;

	localparam logic [31:0] CTPS_RESET = 32'd200000000;

	typedef struct packed {
		logic [1:0]  func;
		logic [31:0] now_tick;
		logic [31:0] rate_hz;
		logic [7:0]  task_handle;
	} in_word_t;

	typedef struct packed {
		logic [7:0]  due_handle;
		logic [1:0]  status;
		logic [31:0] period_out;
		logic [31:0] idle_runs;
		logic        last_of_run;
	} out_word_t;

	// Entry as it travels between cells.
	typedef struct packed {
		logic [31:0] period;
		logic [31:0] last_time;
		logic [7:0]  handle;
	} entry_t;

endpackage

// File: rtl/core/ptd_div.sv
// ----------------------------------------------------------------------------
// ptd_div: 32-bit unsigned restoring divider.
// Produces one quotient bit per cycle, with done raised in the cycle after
// the last step.
// ----------------------------------------------------------------------------
module ptd_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [31:0] divisor,
	output logic        done,
	output logic [31:0] quotient
);
	logic [31:0] rem_q;
	logic [31:0] quo_q;
	logic [31:0] dsr_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic [33:0] trial;

	// One shift-subtract step; the partial remainder can reach 33 bits.
	assign trial = {1'b0, rem_q, quo_q[31]} - {2'b00, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd31) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			if (!trial[33]) begin
				rem_q <= trial[31:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= {rem_q[30:0], quo_q[31]};
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	assign quotient = quo_q;
endmodule

// File: rtl/core/ptd_cell.sv
// ----------------------------------------------------------------------------
// ptd_cell: one table entry of the dispatcher chain.
// Takes its neighbor's entry on every step of a rotation and holds otherwise.
// ----------------------------------------------------------------------------
module ptd_cell #(
	parameter logic [31:0] RST_PERIOD = 32'd0
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            shift,
	input  ptd_pkg::entry_t nbr_entry,
	output ptd_pkg::entry_t entry
);
	import ptd_pkg::*;

	entry_t ent_q;

	// The cell moves one place toward the head when the chain rotates.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_q <= '{period: RST_PERIOD, last_time: 32'd0, handle: 8'd0};
		end else if (shift) begin
			ent_q <= nbr_entry;
		end
	end

	assign entry = ent_q;
endmodule

// File: rtl/core/periodic_task_dispatcher_core.sv
// ----------------------------------------------------------------------------
// periodic_task_dispatcher_core: sorted periodic task table as a cell chain.
// Every walk rotates the whole chain of MAX_ENTRIES cells once through the
// head cell, one entry per cycle in table order while the output is not
// stalled, and the word fed back into the tail carries any change. A tick
// emits one word per due entry; its final word is loaded once the walk is
// over, and a stalled output holds the walk. A query walks the chain once
// as well. A create runs the 32-step serial divider and then inserts during
// the rotation. Rejected creates and queries with handle zero answer in the
// cycle after acceptance. One item is worked at a time; the next word is
// accepted at the earliest in the cycle after the final result is loaded.
// ----------------------------------------------------------------------------
module periodic_task_dispatcher_core #(
	parameter int MAX_ENTRIES = 16,
	parameter int HANDLE_BITS = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [31:0]          cfg_wdata,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  ptd_pkg::in_word_t    in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output ptd_pkg::out_word_t   out_data
);
	import ptd_pkg::*;

	localparam int CW = $clog2(MAX_ENTRIES + 1);
	localparam logic [7:0] H_MASK = 8'((1 << HANDLE_BITS) - 1);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_DIV  = 3'd1;
	localparam logic [2:0] S_WALK = 3'd2;
	localparam logic [2:0] S_OUT  = 3'd3;

	logic [2:0]    state_q;
	logic [31:0]   ctps_q;
	logic [31:0]   idle_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] idx_q;
	logic [1:0]    func_q;
	logic [31:0]   now_q;
	logic [7:0]    hnd_q;
	logic [31:0]   per_q;
	logic          placed_q;
	logic          found_q;
	logic          pend_v_q;
	out_word_t     pend_q;
	entry_t        carry_q;
	out_word_t     res_q;

	entry_t      ent [MAX_ENTRIES];
	entry_t      head;
	entry_t      feed;
	entry_t      new_e;
	out_word_t   res_next;
	logic        res_load;
	logic        accept;
	logic        step;
	logic        fin;
	logic        live;
	logic        due;
	logic        ins;
	logic        div_start;
	logic        div_done;
	logic [31:0] quo;
	logic [7:0]  in_h;
	logic [31:0] idle_next;

	assign in_h      = in_data.task_handle & H_MASK;
	assign head      = ent[0];
	assign in_stall  = (state_q != S_IDLE) || (out_valid && out_stall);
	assign accept    = in_valid && !in_stall;
	assign step      = (state_q == S_WALK) && !(out_valid && out_stall);
	assign fin       = (state_q == S_OUT) && !(out_valid && out_stall);
	assign live      = idx_q < count_q;
	assign due       = (func_q == FUNC_TICK) && live &&
		((now_q - head.last_time) >= head.period);
	assign ins       = (func_q == FUNC_CREATE) && !placed_q &&
		(idx_q == count_q || per_q <= head.period);
	assign idle_next = (head.handle == 8'd0) ? idle_q + 32'd1 : idle_q;
	assign new_e     = '{period: per_q, last_time: 32'd0, handle: hnd_q};

	assign div_start = accept && in_data.func == FUNC_CREATE &&
		count_q < CW'(MAX_ENTRIES) && in_h != 8'd0 && in_data.rate_hz != 32'd0;

	ptd_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.dividend(ctps_q), .divisor(in_data.rate_hz),
		.done(div_done), .quotient(quo)
	);

	// Word fed into the tail: the head entry, stamped when due, or the new
	// entry at the insert point followed by the entries it pushed back.
	always_comb begin
		feed = head;
		if (due)
			feed.last_time = now_q;
		if (ins)
			feed = new_e;
		else if (func_q == FUNC_CREATE && placed_q)
			feed = carry_q;
	end

	// Chain of entry cells; each takes the entry of the cell behind it.
	for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
		ptd_cell #(.RST_PERIOD(g == 0 ? 32'hFFFF_FFFF : 32'd0)) u_cell (
			.clk(clk), .arst_n(arst_n), .shift(step),
			.nbr_entry(g == MAX_ENTRIES - 1 ? feed : ent[(g + 1) % MAX_ENTRIES]),
			.entry(ent[g])
		);
	end

	// Next result word. A due tick word waits in pend_q until the next due
	// entry or the end of the walk shows whether it is the last one.
	always_comb begin
		res_load = 1'b0;
		res_next = pend_q;
		if (accept) begin
			case (in_data.func)
				FUNC_CREATE: begin
					if (count_q >= CW'(MAX_ENTRIES)) begin
						res_load = 1'b1;
						res_next = '{due_handle: 8'd0, status: ST_FULL, period_out: 32'd0,
							idle_runs: idle_q, last_of_run: 1'b1};
					end else if (in_h == 8'd0 || in_data.rate_hz == 32'd0) begin
						res_load = 1'b1;
						res_next = '{due_handle: 8'd0, status: ST_BAD, period_out: 32'd0,
							idle_runs: idle_q, last_of_run: 1'b1};
					end
				end
				FUNC_QUERY: begin
					if (in_h == 8'd0) begin
						res_load = 1'b1;
						res_next = '{due_handle: 8'd0, status: ST_BAD, period_out: 32'd0,
							idle_runs: idle_q, last_of_run: 1'b1};
					end
				end
				default: ;
			endcase
		end else if (step && due && pend_v_q) begin
			res_load = 1'b1;
			res_next = pend_q;
		end else if (fin) begin
			case (func_q)
				FUNC_TICK: begin
					res_load = pend_v_q;
					res_next.last_of_run = 1'b1;
				end
				FUNC_QUERY: begin
					res_load = 1'b1;
					res_next = '{due_handle: 8'd0, status: found_q ? ST_OK : ST_NOTFOUND,
						period_out: found_q ? per_q : 32'd0, idle_runs: idle_q,
						last_of_run: 1'b1};
				end
				FUNC_CREATE: begin
					res_load = 1'b1;
					res_next = '{due_handle: 8'd0, status: ST_OK, period_out: per_q,
						idle_runs: idle_q, last_of_run: 1'b1};
				end
				default: ;
			endcase
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
			res_q     <= '0;
		end else begin
			out_valid <= res_load || (out_valid && out_stall);
			if (res_load)
				res_q <= res_next;
		end
	end

	// Sequencer, table bookkeeping and counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			ctps_q   <= CTPS_RESET;
			idle_q   <= '0;
			count_q  <= CW'(1);
			idx_q    <= '0;
			func_q   <= FUNC_TICK;
			now_q    <= '0;
			hnd_q    <= '0;
			per_q    <= '0;
			placed_q <= 1'b0;
			found_q  <= 1'b0;
			pend_v_q <= 1'b0;
			pend_q   <= '0;
			carry_q  <= '0;
		end else begin
			if (cfg_we)
				ctps_q <= cfg_wdata;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						func_q   <= in_data.func;
						now_q    <= in_data.now_tick;
						hnd_q    <= in_h;
						placed_q <= 1'b0;
						found_q  <= 1'b0;
						pend_v_q <= 1'b0;
						idx_q    <= '0;
						case (in_data.func)
							FUNC_TICK:   state_q <= S_WALK;
							FUNC_CREATE: if (div_start) state_q <= S_DIV;
							FUNC_QUERY:  if (in_h != 8'd0) state_q <= S_WALK;
							default: ;
						endcase
					end
				end
				S_DIV: begin
					if (div_done) begin
						per_q   <= quo;
						state_q <= S_WALK;
					end
				end
				S_WALK: begin
					if (step) begin
						idx_q <= idx_q + CW'(1);
						if (due) begin
							pend_q   <= '{due_handle: head.handle, status: ST_OK,
								period_out: head.period, idle_runs: idle_next,
								last_of_run: 1'b0};
							pend_v_q <= 1'b1;
							idle_q   <= idle_next;
						end
						if (func_q == FUNC_QUERY && live && !found_q && head.handle == hnd_q) begin
							found_q <= 1'b1;
							per_q   <= head.period;
						end
						if (ins || (func_q == FUNC_CREATE && placed_q))
							carry_q <= head;
						if (ins)
							placed_q <= 1'b1;
						if (idx_q == CW'(MAX_ENTRIES - 1))
							state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (fin) begin
						state_q <= S_IDLE;
						if (func_q == FUNC_CREATE)
							count_q <= count_q + CW'(1);
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_data = res_q;
endmodule
